FILE: src/pfq_pkg.sv
`timescale 1ns / 1ps
// Package for the positional FIFO queue: request/response beat types, cell
// control struct, function and status codes. No dependencies.
package pfq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] FN_ENQ     = 3'd0;
  localparam logic [2:0] FN_DEQ     = 3'd1;
  localparam logic [2:0] FN_DEL_VAL = 3'd2;
  localparam logic [2:0] FN_DEL_POS = 3'd3;
  localparam logic [2:0] FN_INS     = 3'd4;
  localparam logic [2:0] FN_CLR     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] head_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
  } rsp_t;

  // Per-cell update: load the request word, take the left (lower index)
  // neighbor, or take the right (higher index) neighbor.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

FILE: src/pfq_cell.sv
`timescale 1ns / 1ps
// One queue slot: holds a data word, compares it against the request word and
// moves data to or from its neighbors. Depends on pfq_pkg.
module pfq_cell import pfq_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] word_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o,
  output logic              match_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = word_i;
    end else if (ctl_i.take_left) begin
      data_d = left_i;
    end else if (ctl_i.take_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == word_i);

endmodule

FILE: src/pfq_ctrl.sv
`timescale 1ns / 1ps
// Request decode for the queue: checks a request against the fill count and
// drives the per-cell shift/load controls. Depends on pfq_pkg.
module pfq_ctrl import pfq_pkg::*; (
  input  logic             accept_i,
  input  req_t             req_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [DEPTH-1:0] match_i,
  output cell_ctl_t        ctl_o [DEPTH],
  output logic [2:0]       status_o,
  output logic [CNT_W-1:0] count_d_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] hit_low;
  logic [DEPTH-1:0] rm_mask;
  logic [CNT_W-1:0] ins_pos;
  logic [CNT_W-1:0] pos_m1;
  logic             do_rm;
  logic             do_ins;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_i);
    end
    hit     = match_i & occ;
    hit_low = hit & (~hit + DEPTH'(1));
    pos_m1  = req_i.position - CNT_W'(1);

    status_o  = ST_OK;
    count_d_o = count_i;
    do_rm     = 1'b0;
    do_ins    = 1'b0;
    rm_mask   = '0;
    ins_pos   = count_i;

    case (req_i.func)
      FN_ENQ: begin
        if (count_i == Full) begin
          status_o = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      FN_DEQ: begin
        if (count_i == '0) begin
          status_o = ST_EMPTY;
        end else begin
          do_rm   = 1'b1;
          rm_mask = '1;
        end
      end
      FN_DEL_VAL: begin
        if (count_i == '0) begin
          status_o = ST_EMPTY;
        end else if (hit == '0) begin
          status_o = ST_NOTFOUND;
        end else begin
          // everything from the first match upward shifts down
          do_rm   = 1'b1;
          rm_mask = ~(hit_low - DEPTH'(1));
        end
      end
      FN_DEL_POS: begin
        if (count_i == '0) begin
          status_o = ST_EMPTY;
        end else if (req_i.position == '0 || req_i.position > count_i) begin
          status_o = ST_BADPOS;
        end else begin
          do_rm = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            rm_mask[i] = (CNT_W'(i) >= pos_m1);
          end
        end
      end
      FN_INS: begin
        if (req_i.position > count_i) begin
          status_o = ST_BADPOS;
        end else if (count_i == Full) begin
          status_o = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          ins_pos = req_i.position;
        end
      end
      FN_CLR: begin
        if (count_i == '0) begin
          status_o = ST_EMPTY;
        end else begin
          count_d_o = '0;
        end
      end
      default: begin
      end
    endcase

    if (do_rm) begin
      count_d_o = count_i - CNT_W'(1);
    end
    if (do_ins) begin
      count_d_o = count_i + CNT_W'(1);
    end

    for (int i = 0; i < DEPTH; i++) begin
      ctl_o[i].load       = accept_i && do_ins && (CNT_W'(i) == ins_pos);
      ctl_o[i].take_left  = accept_i && do_ins && (CNT_W'(i) > ins_pos);
      ctl_o[i].take_right = accept_i && do_rm && rm_mask[i];
    end
  end

endmodule

FILE: src/positional_fifo_queue.sv
`timescale 1ns / 1ps
// Positional FIFO queue: a row of DEPTH cells, each holding one entry and
// shifting to its neighbors; one request is applied per accepted beat.
// The result beat is valid in the cycle after the request beat is accepted.
// Throughput: one request per cycle while out_ready_i takes each result; the
// one result register is free again in the cycle its beat is taken.
// Reset clears the fill count and the result valid; entry data is not reset.
module positional_fifo_queue import pfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [2:0]        status_q;
  logic [2:0]        status_d;
  logic              out_valid_q;
  logic              accept;
  logic [DEPTH-1:0]  match;
  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_ctl_t         ctl [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  pfq_ctrl u_ctrl (
    .accept_i  (accept),
    .req_i     (in_data_i),
    .count_i   (count_q),
    .match_i   (match),
    .ctl_o     (ctl),
    .status_o  (status_d),
    .count_d_o (count_d)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    pfq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .word_i  (in_data_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold status with the beat; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // state only changes on accept, so the result view holds while stalled
  assign out_valid_o           = out_valid_q;
  assign out_data_o.status     = status_q;
  assign out_data_o.head_value = (count_q == '0) ? '0 : cell_data[0];
  assign out_data_o.count      = count_q;
  assign out_data_o.is_empty   = (count_q == '0);

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.func == FN_CLR |=> count_q == '0)
    else $error("clear left entries");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.func == FN_ENQ && count_q != CNT_W'(DEPTH)
    |=> count_q == $past(count_q) + CNT_W'(1) && status_q == ST_OK)
    else $error("enqueue did not grow the queue");

endmodule
